// File: hdl/cwdm_pkg.sv
// ----------------------------------------------------------------------------
// cwdm_pkg
// Shared constants, datapath operation codes and controller/datapath structs
// for the circular window distinct maximum block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwdm_pkg;

  localparam int TYPE_W     = 12;
  localparam int TYPE_COUNT = 1 << TYPE_W;
  localparam int WIN_MAX    = 256;
  localparam int LEN_W      = 9;                   // holds 0..WIN_MAX
  localparam int POS_W      = $clog2(WIN_MAX);     // ring position
  localparam int HEAD_DEPTH = WIN_MAX - 1;
  localparam int HEAD_W     = $clog2(HEAD_DEPTH);
  localparam int CNT_W      = 9;                   // per-type count, distinct count
  localparam int SCORE_W    = 9;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUPON_TYPE   = 4'd1;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
  localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd2;
  localparam logic [OP_W-1:0] OP_FILL_RD   = 4'd3;
  localparam logic [OP_W-1:0] OP_FILL_WR   = 4'd4;
  localparam logic [OP_W-1:0] OP_WS_RD     = 4'd5;
  localparam logic [OP_W-1:0] OP_OLD_RD    = 4'd6;
  localparam logic [OP_W-1:0] OP_OLD_WR    = 4'd7;
  localparam logic [OP_W-1:0] OP_NEW_WR    = 4'd8;
  localparam logic [OP_W-1:0] OP_HD_RD     = 4'd9;
  localparam logic [OP_W-1:0] OP_RP_OLD_RD = 4'd10;
  localparam logic [OP_W-1:0] OP_RP_NEW_WR = 4'd11;
  localparam logic [OP_W-1:0] OP_DR_RD     = 4'd12;
  localparam logic [OP_W-1:0] OP_DR_HRD    = 4'd13;
  localparam logic [OP_W-1:0] OP_DR_WR     = 4'd14;
  localparam logic [OP_W-1:0] OP_OUT       = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;     // last histogram entry being cleared
    logic fill;         // window not yet full
    logic last;         // current word carries the last mark
    logic short_stream; // stream ended before the window filled
    logic len_one;      // window of one item: nothing to replay
    logic rp_last;      // final replay step
    logic dr_last;      // final drain step
    logic out_free;     // result register can take a word
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/cwdm_item_if.sv
// ----------------------------------------------------------------------------
// cwdm_item_if
// Input channel: one item type per word with a last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdm_item_if import cwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] item_type;
  logic              last;

  modport source (output valid, output item_type, output last, input ready);
  modport sink   (input valid, input item_type, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/cwdm_result_if.sv
// ----------------------------------------------------------------------------
// cwdm_result_if
// Result channel: best window score and short stream flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdm_result_if import cwdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] best_score;
  logic               short_stream;

  modport source (output valid, output best_score, output short_stream, input ready);
  modport sink   (input valid, input best_score, input short_stream, output ready);
endinterface

`default_nettype wire

// File: hdl/cwdm_cfg_if.sv
// ----------------------------------------------------------------------------
// cwdm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdm_cfg_if import cwdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cwdm_ctrl.sv
// ----------------------------------------------------------------------------
// cwdm_ctrl
// Sequencer: histogram clear after reset, per-item fill or slide steps,
// replay of the head items after the last word, drain, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdm_ctrl import cwdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_START     = 4'd2;
  localparam logic [3:0] S_FILL_WR   = 4'd3;
  localparam logic [3:0] S_OLD_RD    = 4'd4;
  localparam logic [3:0] S_OLD_WR    = 4'd5;
  localparam logic [3:0] S_NEW_WR    = 4'd6;
  localparam logic [3:0] S_END       = 4'd7;
  localparam logic [3:0] S_HD_RD     = 4'd8;
  localparam logic [3:0] S_RP_OLD_RD = 4'd9;
  localparam logic [3:0] S_RP_OLD_WR = 4'd10;
  localparam logic [3:0] S_RP_NEW_WR = 4'd11;
  localparam logic [3:0] S_DR_RD     = 4'd12;
  localparam logic [3:0] S_DR_HRD    = 4'd13;
  localparam logic [3:0] S_DR_WR     = 4'd14;
  localparam logic [3:0] S_DONE      = 4'd15;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.fill) begin
          cmd.op     = OP_FILL_RD;
          state_next = S_FILL_WR;
        end else begin
          cmd.op     = OP_WS_RD;
          state_next = S_OLD_RD;
        end
      end
      S_FILL_WR: begin
        cmd.op     = OP_FILL_WR;
        state_next = sts.last ? S_END : S_IDLE;
      end
      S_OLD_RD: begin
        cmd.op     = OP_OLD_RD;
        state_next = S_OLD_WR;
      end
      S_OLD_WR: begin
        cmd.op     = OP_OLD_WR;
        state_next = S_NEW_WR;
      end
      S_NEW_WR: begin
        cmd.op     = OP_NEW_WR;
        state_next = sts.last ? S_END : S_IDLE;
      end
      S_END: begin
        // short stream or one-item window: straight to drain
        state_next = (sts.short_stream || sts.len_one) ? S_DR_RD : S_HD_RD;
      end
      S_HD_RD: begin
        cmd.op     = OP_HD_RD;
        state_next = S_RP_OLD_RD;
      end
      S_RP_OLD_RD: begin
        cmd.op     = OP_RP_OLD_RD;
        state_next = S_RP_OLD_WR;
      end
      S_RP_OLD_WR: begin
        cmd.op     = OP_OLD_WR;
        state_next = S_RP_NEW_WR;
      end
      S_RP_NEW_WR: begin
        cmd.op     = OP_RP_NEW_WR;
        state_next = sts.rp_last ? S_DR_RD : S_HD_RD;
      end
      S_DR_RD: begin
        cmd.op     = OP_DR_RD;
        state_next = S_DR_HRD;
      end
      S_DR_HRD: begin
        cmd.op     = OP_DR_HRD;
        state_next = S_DR_WR;
      end
      S_DR_WR: begin
        cmd.op     = OP_DR_WR;
        state_next = sts.dr_last ? S_DONE : S_DR_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/cwdm_datapath.sv
// ----------------------------------------------------------------------------
// cwdm_datapath
// Type histogram, window ring and head store memories, distinct and coupon
// counters, score tracking, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdm_datapath import cwdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  cwdm_cfg_if.sink               cfg,
  input  wire logic [TYPE_W-1:0] item_type,
  input  wire logic              last,
  cwdm_result_if.source          results
);

  // memories
  logic [CNT_W-1:0]  hist_mem [TYPE_COUNT];
  logic [TYPE_W-1:0] ws_mem   [WIN_MAX];
  logic [TYPE_W-1:0] hs_mem   [HEAD_DEPTH];

  logic [CNT_W-1:0]  hist_q;
  logic [TYPE_W-1:0] ws_q;
  logic [TYPE_W-1:0] hs_q;

  logic              hist_we, hist_re;
  logic [TYPE_W-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0]  hist_wdata;
  logic              ws_we, ws_re;
  logic [POS_W-1:0]  ws_raddr;
  logic              hs_we, hs_re;

  // registers
  logic [LEN_W-1:0]   cfg_len, cur_len;
  logic [TYPE_W-1:0]  cfg_coupon, cur_coupon;
  logic [TYPE_W-1:0]  t_q;
  logic               last_q;
  logic [LEN_W-1:0]   items_seen, j;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   distinct, coupon_cnt, fwd;
  logic               hit;
  logic [SCORE_W-1:0] best;
  logic [TYPE_W-1:0]  clr_addr;
  logic               out_valid;
  logic [SCORE_W-1:0] out_best;
  logic               out_short;

  // combinational helpers
  logic [LEN_W-1:0]   len_clamped;
  logic [LEN_W-1:0]   pos_plus;
  logic [POS_W-1:0]   pos_adv;
  logic [LEN_W:0]     seen_plus, j_plus, j_plus2, drain_n;
  logic [CNT_W-1:0]   hq_dec, cnt_cur;
  logic [CNT_W-1:0]   distinct_add, coupon_add;
  logic [SCORE_W-1:0] score;
  logic               is_short;

  always_comb begin
    if (cfg_len == '0) begin
      len_clamped = LEN_W'(1);
    end else if (cfg_len > LEN_W'(WIN_MAX)) begin
      len_clamped = LEN_W'(WIN_MAX);
    end else begin
      len_clamped = cfg_len;
    end
  end

  assign pos_plus  = LEN_W'(pos) + LEN_W'(1);
  assign pos_adv   = (pos_plus == cur_len) ? '0 : pos_plus[POS_W-1:0];
  assign seen_plus = {1'b0, items_seen} + (LEN_W+1)'(1);
  assign j_plus    = {1'b0, j} + (LEN_W+1)'(1);
  assign j_plus2   = {1'b0, j} + (LEN_W+1)'(2);
  assign is_short  = items_seen < cur_len;
  assign drain_n   = is_short ? {1'b0, items_seen} : {1'b0, cur_len};

  assign hq_dec  = (hist_q != '0) ? hist_q - CNT_W'(1) : hist_q;
  // the entering type may equal the type just removed: its read was stale
  assign cnt_cur = hit ? fwd : hist_q;

  assign distinct_add = distinct + {{(CNT_W-1){1'b0}}, (cnt_cur == '0)};
  assign coupon_add   = coupon_cnt + {{(CNT_W-1){1'b0}}, (t_q == cur_coupon)};
  assign score        = SCORE_W'(distinct_add) + {{(SCORE_W-1){1'b0}}, (coupon_add == '0)};

  assign sts.clr_last     = (clr_addr == TYPE_W'(TYPE_COUNT - 1));
  assign sts.fill         = is_short;
  assign sts.last         = last_q;
  assign sts.short_stream = is_short;
  assign sts.len_one      = (cur_len == LEN_W'(1));
  assign sts.rp_last      = (j_plus2 == {1'b0, cur_len});
  assign sts.dr_last      = (j_plus == drain_n);
  assign sts.out_free     = !out_valid || results.ready;

  // memory port control
  always_comb begin
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = t_q;
    hist_raddr = t_q;
    hist_wdata = cnt_cur + CNT_W'(1);
    ws_we      = 1'b0;
    ws_re      = 1'b0;
    ws_raddr   = pos;
    hs_we      = 1'b0;
    hs_re      = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr;
        hist_wdata = '0;
      end
      OP_FILL_RD: begin
        hist_re = 1'b1;
        ws_we   = 1'b1;
        hs_we   = seen_plus < {1'b0, cur_len};
      end
      OP_FILL_WR, OP_NEW_WR, OP_RP_NEW_WR: begin
        hist_we = 1'b1;
      end
      OP_WS_RD: begin
        ws_re = 1'b1;
      end
      OP_OLD_RD, OP_RP_OLD_RD, OP_DR_HRD: begin
        hist_re    = 1'b1;
        hist_raddr = ws_q;
      end
      OP_OLD_WR: begin
        hist_we    = 1'b1;
        hist_waddr = ws_q;
        hist_wdata = hq_dec;
        hist_re    = 1'b1;
        ws_we      = 1'b1;
      end
      OP_HD_RD: begin
        ws_re = 1'b1;
        hs_re = 1'b1;
      end
      OP_DR_RD: begin
        ws_re    = 1'b1;
        ws_raddr = j[POS_W-1:0];
      end
      OP_DR_WR: begin
        hist_we    = 1'b1;
        hist_waddr = ws_q;
        hist_wdata = hq_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (ws_we) ws_mem[pos] <= t_q;
    if (ws_re) ws_q <= ws_mem[ws_raddr];
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[items_seen[HEAD_W-1:0]] <= t_q;
    if (hs_re) hs_q <= hs_mem[j[HEAD_W-1:0]];
  end

  assign cfg.ready = 1'b1;

  // control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len    <= LEN_W'(1);
      cfg_coupon <= '0;
      cur_len    <= LEN_W'(1);
      cur_coupon <= '0;
      last_q     <= 1'b0;
      items_seen <= '0;
      j          <= '0;
      pos        <= '0;
      distinct   <= '0;
      coupon_cnt <= '0;
      hit        <= 1'b0;
      best       <= '0;
      clr_addr   <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_WINDOW_LENGTH: cfg_len    <= cfg.data[LEN_W-1:0];
          REG_COUPON_TYPE:   cfg_coupon <= cfg.data[TYPE_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_CLEAR: begin
          clr_addr <= clr_addr + TYPE_W'(1);
        end
        OP_ACCEPT: begin
          last_q <= last;
          j      <= '0;
          hit    <= 1'b0;
          if (items_seen == '0) begin
            cur_len    <= len_clamped;
            cur_coupon <= cfg_coupon;
            pos        <= '0;
            distinct   <= '0;
            coupon_cnt <= '0;
            best       <= '0;
          end
        end
        OP_FILL_WR: begin
          distinct   <= distinct_add;
          coupon_cnt <= coupon_add;
          items_seen <= seen_plus[LEN_W-1:0];
          pos        <= pos_adv;
          if (seen_plus == {1'b0, cur_len} && score > best) best <= score;
        end
        OP_OLD_WR: begin
          hit <= (ws_q == t_q);
          if (hist_q == CNT_W'(1) && distinct != '0) distinct <= distinct - CNT_W'(1);
          if (ws_q == cur_coupon && hist_q != '0) coupon_cnt <= coupon_cnt - CNT_W'(1);
        end
        OP_NEW_WR, OP_RP_NEW_WR: begin
          distinct   <= distinct_add;
          coupon_cnt <= coupon_add;
          pos        <= pos_adv;
          if (score > best) best <= score;
          if (cmd.op == OP_RP_NEW_WR) j <= sts.rp_last ? '0 : j_plus[LEN_W-1:0];
        end
        OP_DR_WR: begin
          j <= sts.dr_last ? '0 : j_plus[LEN_W-1:0];
        end
        OP_OUT: begin
          items_seen <= '0;
          pos        <= '0;
          distinct   <= '0;
          coupon_cnt <= '0;
          best       <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT:    t_q <= item_type;
      OP_RP_OLD_RD: t_q <= hs_q;
      default: ;
    endcase
    if (cmd.op == OP_OLD_WR) fwd <= hq_dec;
    if (cmd.op == OP_OUT) begin
      out_best  <= is_short ? '0 : best;
      out_short <= is_short;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid        = out_valid;
  assign results.best_score   = out_best;
  assign results.short_stream = out_short;

endmodule

`default_nettype wire

// File: hdl/circular_window_distinct_max_core.sv
// ----------------------------------------------------------------------------
// circular_window_distinct_max_core
// Each fill or sliding item is a histogram read-modify-write on one memory
// port pair, old type removed before new added. The last word adds a replay
// of the L-1 head items (none for a short stream), a drain of L items (the
// items seen, for a short stream) and the result hand-off; one word per stream.
// After reset all 4096 histogram entries are cleared, one entry a cycle, before
// the first item is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_window_distinct_max_core import cwdm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  cwdm_item_if.sink     items,
  cwdm_result_if.source results,
  cwdm_cfg_if.sink      cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign items.ready = in_ready;

  cwdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cwdm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .item_type (items.item_type),
    .last      (items.last),
    .results   (results)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_circular_window_distinct_max_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_window_distinct_max_core
// Streams of item types go in through a clocked driver; a clocked monitor
// tracks the circular-window histogram on every accepted word, queues the
// score due at each last mark, and checks each result word against it.
// Settings range over single, small, large and saturated window lengths.
// ----------------------------------------------------------------------------

module tb_circular_window_distinct_max_core;
  import cwdm_pkg::*;

  localparam int IDLE_PCT      = 34;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEM_TARGET   = 1350;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 32;
  localparam int QUIET_LIMIT   = 20000;
  localparam int REPORT_MAX    = 10;

  // indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 4'hF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_MID = 4'hA;

  typedef struct {
    logic [TYPE_W-1:0] item_type;
    logic              last;
  } item_word_t;

  typedef struct {
    logic [SCORE_W-1:0] best_score;
    logic               short_stream;
  } score_word_t;

  logic clk;
  logic rst = 1'b1;

  cwdm_item_if   item_ch ();
  cwdm_result_if result_ch ();
  cwdm_cfg_if    cfg_ch ();

  circular_window_distinct_max_core uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  item_word_t  pending_items [$];
  score_word_t due_scores [$];
  item_word_t  next_word;
  score_word_t due_word;

  logic item_fire  = 1'b0;
  logic cfg_fire   = 1'b0;
  logic no_idle;
  logic hold_start;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   items_pushed;
  int   error_count  = 0;
  int   quiet_cycles = 0;

  // window tracking state
  logic [CNT_W-1:0]   hist_count [TYPE_COUNT] = '{default: '0};
  logic [TYPE_W-1:0]  ring_types [WIN_MAX];
  logic [TYPE_W-1:0]  head_types [WIN_MAX];
  logic [CNT_W-1:0]   distinct_types = '0;
  logic [SCORE_W-1:0] best_window    = '0;
  logic [LEN_W-1:0]   fill_count     = '0;
  logic [LEN_W-1:0]   ring_idx       = '0;
  logic [LEN_W-1:0]   cfg_window_len = LEN_W'(1);
  logic [TYPE_W-1:0]  cfg_coupon     = '0;
  logic [LEN_W-1:0]   stream_len     = LEN_W'(1);
  logic [TYPE_W-1:0]  stream_coupon  = '0;

  function automatic void count_in(input logic [TYPE_W-1:0] t);
    if (hist_count[t] == '0) distinct_types++;
    hist_count[t]++;
  endfunction

  function automatic void count_out(input logic [TYPE_W-1:0] t);
    if (hist_count[t] != '0) begin
      hist_count[t]--;
      if (hist_count[t] == '0 && distinct_types != '0) distinct_types--;
    end
  endfunction

  function automatic void advance_ring();
    if (ring_idx + 1 == stream_len) ring_idx = '0;
    else ring_idx = ring_idx + 1'b1;
  endfunction

  function automatic void score_window();
    logic [SCORE_W-1:0] s;
    s = distinct_types;
    if (hist_count[stream_coupon] == '0) s = s + 1'b1;
    if (s > best_window) best_window = s;
  endfunction

  function automatic void slide_window(input logic [TYPE_W-1:0] t);
    count_out(ring_types[ring_idx[POS_W-1:0]]);
    count_in(t);
    ring_types[ring_idx[POS_W-1:0]] = t;
    advance_ring();
    score_window();
  endfunction

  function automatic void track_item(input logic [TYPE_W-1:0] t, input logic last);
    score_word_t w;
    int j;
    if (fill_count == '0) begin
      stream_len = cfg_window_len;
      if (stream_len == '0) stream_len = LEN_W'(1);
      if (stream_len > WIN_MAX) stream_len = LEN_W'(WIN_MAX);
      stream_coupon  = cfg_coupon;
      ring_idx       = '0;
      distinct_types = '0;
      best_window    = '0;
    end
    if (fill_count < stream_len) begin
      count_in(t);
      ring_types[ring_idx[POS_W-1:0]] = t;
      if (fill_count + 1 < stream_len) head_types[fill_count[POS_W-1:0]] = t;
      fill_count++;
      advance_ring();
      if (fill_count == stream_len) score_window();
    end else begin
      slide_window(t);
    end
    if (last) begin
      if (fill_count < stream_len) begin
        for (j = 0; j < fill_count; j++) count_out(ring_types[POS_W'(j)]);
        w.best_score   = '0;
        w.short_stream = 1'b1;
      end else begin
        // replay the head for the wrap windows, then empty the window
        for (j = 0; j + 1 < stream_len; j++) slide_window(head_types[POS_W'(j)]);
        for (j = 0; j < stream_len; j++) count_out(ring_types[POS_W'(j)]);
        w.best_score   = best_window;
        w.short_stream = 1'b0;
      end
      due_scores.push_back(w);
      fill_count     = '0;
      ring_idx       = '0;
      distinct_types = '0;
      best_window    = '0;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WINDOW_LENGTH) cfg_window_len = data[LEN_W-1:0];
    else if (idx == REG_COUPON_TYPE) cfg_coupon = data[TYPE_W-1:0];
  endfunction

  task automatic push_item(input logic [TYPE_W-1:0] t, input logic last);
    item_word_t w;
    w.item_type = t;
    w.last      = last;
    pending_items.push_back(w);
    items_pushed++;
  endtask

  task automatic push_stream(input int n, input logic [TYPE_W-1:0] base, input int span);
    int k;
    for (k = 0; k < n; k++)
      push_item(base + TYPE_W'($urandom_range(0, span - 1)), k == n - 1);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // hold the sender until every due score is back, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || item_ch.valid || due_scores.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: a word stays up until taken
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid     <= 1'b0;
      item_ch.item_type <= '0;
      item_ch.last      <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_word = pending_items.pop_front();
        item_ch.valid     <= 1'b1;
        item_ch.item_type <= next_word.item_type;
        item_ch.last      <= next_word.last;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    item_fire <= !rst && item_ch.valid === 1'b1 && item_ch.ready === 1'b1;
    cfg_fire  <= !rst && cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1;
    if (!rst) begin
      quiet_cycles++;
      if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
        track_item(item_ch.item_type, item_ch.last);
        quiet_cycles = 0;
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        apply_register(cfg_ch.index, cfg_ch.data);
        quiet_cycles = 0;
      end
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        quiet_cycles = 0;
        if (due_scores.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: result word with none due: best_score=%0d short_stream=%0b",
                     $time, result_ch.best_score, result_ch.short_stream);
        end else begin
          due_word = due_scores.pop_front();
          if (result_ch.best_score !== due_word.best_score ||
              result_ch.short_stream !== due_word.short_stream) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("%0t: mismatch: expected best_score=%0d short_stream=%0b, got %0d %0b",
                       $time, due_word.best_score, due_word.short_stream,
                       result_ch.best_score, result_ch.short_stream);
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int p, r, k, n, eff, span, extra, nstreams, short_pct;
    logic [TYPE_W-1:0]     base;
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] data;

    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    no_idle      = 1'b0;
    hold_start   = 1'b0;
    items_pushed = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset settings: window of one, coupon type zero
    push_item(12'd0, 1'b1);
    push_item(12'd4095, 1'b1);
    wait_idle();

    // zero length is taken as one
    cfg_write(REG_WINDOW_LENGTH, 12'h000);
    push_item(12'd7, 1'b0);
    push_item(12'd7, 1'b0);
    push_item(12'd8, 1'b1);
    wait_idle();

    // upper data bits are dropped: length 3
    cfg_write(REG_WINDOW_LENGTH, 12'hE03);
    cfg_write(REG_COUPON_TYPE, 12'd5);
    push_item(12'd5, 1'b0);
    push_item(12'd9, 1'b1);
    push_item(12'd5, 1'b0);
    push_item(12'd6, 1'b0);
    push_item(12'd7, 1'b1);
    push_item(12'd1, 1'b0);
    push_item(12'd1, 1'b0);
    push_item(12'd5, 1'b0);
    push_item(12'd2, 1'b0);
    push_item(12'd2, 1'b1);
    wait_idle();

    // unused indexes must leave the registers alone
    cfg_write(REG_UNUSED_HI, 12'hFFF);
    cfg_write(REG_UNUSED_MID, 12'h555);
    push_item(12'd5, 1'b0);
    push_item(12'd5, 1'b0);
    push_item(12'd5, 1'b1);
    wait_idle();

    // length saturates at the window maximum; two items fall short
    cfg_write(REG_WINDOW_LENGTH, 12'h1FF);
    cfg_write(REG_COUPON_TYPE, 12'hFFF);
    push_item(12'd4095, 1'b0);
    push_item(12'd0, 1'b1);
    len_reg = 9'h1FF;

    p = 0;
    while (items_pushed < ITEM_TARGET) begin
      wait_idle();
      no_idle = (p >= 4 && p <= 7);
      if (p == 0) begin
        // full window of distinct types with the coupon absent: top score
        base = TYPE_W'($urandom);
        len_reg = 256;
        cfg_write(REG_WINDOW_LENGTH, 12'd256);
        cfg_write(REG_COUPON_TYPE, base - 1'b1);
        for (k = 0; k < 256; k++) push_item(base + TYPE_W'(k), 1'b0);
        extra = $urandom_range(0, 16);
        for (k = 0; k < extra; k++) push_item(TYPE_W'($urandom), 1'b0);
        push_item(TYPE_W'($urandom), 1'b1);
      end else if (p == 2) begin
        // results held back while streams of one to five items keep coming
        len_reg = 2;
        cfg_write(REG_WINDOW_LENGTH, 12'd2);
        cfg_write(REG_COUPON_TYPE, CFG_DATA_W'($urandom_range(0, 3)));
        hold_start = 1'b1;
        repeat (12) push_stream($urandom_range(1, 5), '0, 4);
      end else begin
        if ($urandom_range(0, 99) < 80) begin
          r = $urandom_range(0, 99);
          if (r < 60) len_reg = LEN_W'($urandom_range(1, 8));
          else if (r < 85) len_reg = LEN_W'($urandom_range(9, 32));
          else if (r < 95) len_reg = LEN_W'($urandom_range(33, 128));
          else begin
            case ($urandom_range(0, 3))
              0: len_reg = 0;
              1: len_reg = 255;
              2: len_reg = 300;
              default: len_reg = 511;
            endcase
          end
          data = CFG_DATA_W'($urandom);
          data[LEN_W-1:0] = len_reg;
          cfg_write(REG_WINDOW_LENGTH, data);
        end
        eff = (len_reg == 0) ? 1 : (len_reg > WIN_MAX) ? WIN_MAX : len_reg;
        span = ($urandom_range(0, 9) == 0) ? TYPE_COUNT : $urandom_range(1, 2 * eff + 2);
        base = TYPE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50) cfg_write(REG_COUPON_TYPE, base + TYPE_W'($urandom_range(0, span - 1)));
        else if (r < 80) cfg_write(REG_COUPON_TYPE, CFG_DATA_W'($urandom));
        nstreams = (eff > 64) ? 1 : $urandom_range(1, 4);
        short_pct = (eff > 64) ? 50 : 20;
        repeat (nstreams) begin
          r = $urandom_range(0, 99);
          if (eff > 1 && r < short_pct)
            n = (r < 5) ? eff - 1 : $urandom_range(1, (eff - 1 < 16) ? eff - 1 : 16);
          else if (r < short_pct + 15)
            n = eff;
          else
            n = eff + $urandom_range(0, (eff < 12) ? 2 * eff + 4 : 12);
          push_stream(n, base, span);
        end
      end
      p++;
    end

    wait_idle();
    if (error_count == 0 && due_scores.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cwdm_pkg.sv
hdl/cwdm_item_if.sv
hdl/cwdm_result_if.sv
hdl/cwdm_cfg_if.sv
hdl/cwdm_ctrl.sv
hdl/cwdm_datapath.sv
hdl/circular_window_distinct_max_core.sv
tb/sv/tb_circular_window_distinct_max_core.sv
